/* hdl/lcdp_pkg.sv */
// Shared types and constants for the line command duty parser.
`default_nettype none

package lcdp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LineCntW = 4;
  localparam int unsigned ValueW   = 7;
  localparam int unsigned DutyW    = 8;

  localparam logic [LineCntW-1:0] MaxLine  = 4'd15;
  localparam logic [ValueW-1:0]   SatValue = 7'd101;
  localparam logic [ValueW-1:0]   MaxValue = 7'd100;
  localparam logic [DutyW-1:0]    DutyFull = 8'd255;
  localparam logic [DutyW-1:0]    DutyZero = 8'd0;

  // floor(v*255/100) == (v * DutyRecip) >> DutyShift for v in 0..100
  localparam int unsigned          DutyShift = 16;
  localparam int unsigned          RecipW    = 18;
  localparam logic [RecipW-1:0]    DutyRecip = 18'd167117;

  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChVt    = 8'h0b;
  localparam logic [ByteW-1:0] ChFf    = 8'h0c;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2b;
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChO     = 8'h4f;
  localparam logic [ByteW-1:0] ChN     = 8'h4e;
  localparam logic [ByteW-1:0] ChF     = 8'h46;

  typedef enum logic [1:0] {
    RespOn      = 2'd0,
    RespOff     = 2'd1,
    RespChanged = 2'd2,
    RespInvalid = 2'd3
  } resp_e;

  // what the parser reports about the line it just closed
  typedef struct packed {
    logic              done;
    logic              is_on;
    logic              is_off;
    logic              num_ok;
    logic [ValueW-1:0] value;
  } line_info_t;

endpackage

`default_nettype wire

/* hdl/lcdp_line_parser.sv */
// Per-line character state: keyword match, atoi-style number reader, line length.
`default_nettype none

module lcdp_line_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [lcdp_pkg::ByteW-1:0] byte_i,
  output      lcdp_pkg::line_info_t      info_o
);
  import lcdp_pkg::*;

  typedef enum logic [2:0] {
    KwEmpty = 3'd0,
    KwO     = 3'd1,
    KwOn    = 3'd2,
    KwOf    = 3'd3,
    KwOff   = 3'd4,
    KwNone  = 3'd5
  } kw_e;

  typedef enum logic [1:0] {
    PhSpace  = 2'd0,
    PhSign   = 2'd1,
    PhDigits = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  logic [LineCntW-1:0] cnt_q, cnt_d;
  logic                ended_q, ended_d;
  kw_e                 kw_q, kw_d;
  phase_e              ph_q, ph_d;
  logic                neg_q, neg_d;
  logic [ValueW-1:0]   val_q, val_d;

  logic                is_eol, is_ws, is_sign, is_digit;
  logic [9:0]          acc;
  logic                done;

  always_comb begin
    is_eol   = (byte_i == ChCr) || (byte_i == ChLf);
    is_ws    = (byte_i == ChSpace) || (byte_i == ChTab) ||
               (byte_i == ChVt) || (byte_i == ChFf);
    is_sign  = (byte_i == ChPlus) || (byte_i == ChMinus);
    is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
    acc      = {val_q, 3'b000} + {2'b00, val_q, 1'b0} + {6'd0, 4'(byte_i - ChZero)};

    cnt_d   = cnt_q;
    ended_d = ended_q;
    kw_d    = kw_q;
    ph_d    = ph_q;
    neg_d   = neg_q;
    val_d   = val_q;

    if (!is_eol) begin
      cnt_d = cnt_q + 4'd1;
      if (!ended_q) begin
        if (byte_i == ChNul) begin
          ended_d = 1'b1;
        end else begin
          case (kw_q)
            KwEmpty: kw_d = (byte_i == ChO) ? KwO : KwNone;
            KwO: begin
              if (byte_i == ChN) kw_d = KwOn;
              else if (byte_i == ChF) kw_d = KwOf;
              else kw_d = KwNone;
            end
            KwOf:    kw_d = (byte_i == ChF) ? KwOff : KwNone;
            default: kw_d = KwNone;
          endcase

          if (ph_q == PhSpace && is_ws) begin
            ph_d = ph_q;
          end else if (ph_q == PhSpace && is_sign) begin
            neg_d = (byte_i == ChMinus);
            ph_d  = PhSign;
          end else if (ph_q != PhDone) begin
            if (is_digit) begin
              val_d = (acc > {3'd0, SatValue}) ? SatValue : acc[ValueW-1:0];
              ph_d  = PhDigits;
            end else begin
              ph_d = PhDone;
            end
          end
        end
      end
    end

    done = is_eol || (cnt_d == MaxLine);

    info_o.done   = done;
    info_o.is_on  = (kw_d == KwOn);
    info_o.is_off = (kw_d == KwOff);
    info_o.num_ok = !neg_d && (val_d != '0) && (val_d <= MaxValue);
    info_o.value  = val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ended_q <= 1'b0;
      kw_q    <= KwEmpty;
      ph_q    <= PhSpace;
      neg_q   <= 1'b0;
      val_q   <= '0;
    end else if (step_i) begin
      if (done) begin
        cnt_q   <= '0;
        ended_q <= 1'b0;
        kw_q    <= KwEmpty;
        ph_q    <= PhSpace;
        neg_q   <= 1'b0;
        val_q   <= '0;
      end else begin
        cnt_q   <= cnt_d;
        ended_q <= ended_d;
        kw_q    <= kw_d;
        ph_q    <= ph_d;
        neg_q   <= neg_d;
        val_q   <= val_d;
      end
    end
  end

`ifndef SYNTHESIS
  // line length never reaches the limit while held
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != MaxLine)
    else $error("line count reached limit without closing");
  // accumulator never passes the saturation value
  assert property (@(posedge clk_i) disable iff (!rst_ni) val_q <= SatValue)
    else $error("digit accumulator above saturation");
  // a closed line leaves a clean state behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> cnt_q == '0 && val_q == '0 && kw_q == KwEmpty)
    else $error("line state not cleared after line end");
`endif

endmodule

`default_nettype wire

/* hdl/line_command_duty_parser.sv */
// A word accepted into the input register is parsed; its result, if any, reaches the outputs from the result register.
// Throughput: one word per cycle unless a waiting result is not taken; input register, line parser, result register.
// A word is taken while a finished result still waits, as long as the input slot is empty.
// Reset: asynchronous, active low; clears the line state, valid flags and duty to 0.
// Results appear only at line ends (CR, LF or the 15th stored character).
`default_nettype none

module line_command_duty_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [lcdp_pkg::ByteW-1:0] rx_byte_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic [1:0]                 response_o,
  output      logic [lcdp_pkg::DutyW-1:0] duty_o
);
  import lcdp_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  resp_e            resp_q, resp_d;
  logic [DutyW-1:0] duty_q, duty_d;

  logic             advance, step;
  line_info_t       info;
  logic [ValueW+RecipW-1:0] prod;

  lcdp_line_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .info_o (info)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    prod = {{RecipW{1'b0}}, info.value} * {{ValueW{1'b0}}, DutyRecip};
    if (info.is_on) begin
      resp_d = RespOn;
      duty_d = DutyFull;
    end else if (info.is_off) begin
      resp_d = RespOff;
      duty_d = DutyZero;
    end else if (info.num_ok) begin
      resp_d = RespChanged;
      duty_d = prod[DutyShift +: DutyW];
    end else begin
      resp_d = RespInvalid;
      duty_d = duty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      duty_q      <= '0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= step && info.done;
      if (step && info.done) duty_q <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_byte_q <= rx_byte_i;
    if (step && info.done) resp_q <= resp_d;
  end

  assign out_valid_o = out_valid_q;
  assign response_o  = resp_q;
  assign duty_o      = duty_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && resp_q == RespOn |-> duty_q == DutyFull)
    else $error("led on result without full duty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && resp_q == RespOff |-> duty_q == DutyZero)
    else $error("led off result with nonzero duty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && resp_q == RespInvalid |=> duty_q == $past(duty_q))
    else $error("duty moved while invalid result held");
`endif

endmodule

`default_nettype wire
